/* rtl/rssp_pkg.sv */
package rssp_pkg;

   localparam int unsigned SpeedW   = 14;
   localparam int unsigned StepW    = 12;
   localparam int unsigned RpmW     = 8;
   localparam int unsigned PosW     = 16;
   localparam int unsigned CmdW     = 15;
   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned CsrDataW = 14;
   localparam int unsigned ReqDataW = 40;
   localparam int unsigned RspDataW = 32;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_MAX_SPEED  = 2'd0,
      CSR_SLOW_SPEED = 2'd1,
      CSR_SPEED_STEP = 2'd2,
      CSR_STOP_RPM   = 2'd3
   } csr_addr_type;

   localparam logic [SpeedW-1:0] MaxSpeedRst  = 14'd8000;
   localparam logic [SpeedW-1:0] SlowSpeedRst = 14'd5000;
   localparam logic [StepW-1:0]  SpeedStepRst = 12'd500;
   localparam logic [RpmW-1:0]   StopRpmRst   = 8'd5;

   // landmark positions, picked by direction of travel
   localparam logic signed [PosW-1:0] LmRightR = -16'sd55;
   localparam logic signed [PosW-1:0] LmRightL = -16'sd114;
   localparam logic signed [PosW-1:0] LmLeftR  = -16'sd235;
   localparam logic signed [PosW-1:0] LmLeftL  = -16'sd275;

   // zone edges
   localparam logic signed [PosW-1:0] ZlA = -16'sd150;
   localparam logic signed [PosW-1:0] ZlB = -16'sd240;
   localparam logic signed [PosW-1:0] ZlC = -16'sd303;
   localparam logic signed [PosW-1:0] ZrA = -16'sd245;
   localparam logic signed [PosW-1:0] ZrB = -16'sd160;
   localparam logic signed [PosW-1:0] ZrC = -16'sd31;

   typedef struct packed {
      logic [SpeedW-1:0] max_speed;
      logic [SpeedW-1:0] slow_speed;
      logic [StepW-1:0]  speed_step;
      logic [RpmW-1:0]   stop_rpm;
   } cfg_type;

   typedef struct packed {
      logic              travel_right;
      logic [SpeedW-1:0] speed;
      logic [PosW-1:0]   offset;
      logic              last_right_beam;
      logic              last_left_beam;
   } state_type;

   typedef struct packed {
      logic                   right_beam;
      logic                   left_beam;
      logic signed [PosW-1:0] encoder_position;
      logic signed [PosW-1:0] motor_speed;
   } item_type;

   typedef struct packed {
      logic signed [CmdW-1:0] speed_command;
      logic                   moving_right;
      logic signed [PosW-1:0] track_position;
   } result_type;

endpackage

/* rtl/rssp_step.sv */
module rssp_step (
   input  rssp_pkg::cfg_type    cfg,
   input  rssp_pkg::state_type  state,
   input  rssp_pkg::item_type   item,
   output rssp_pkg::state_type  state_next,
   output rssp_pkg::result_type result
);

   typedef enum logic [1:0] {
      ZONE_UP,
      ZONE_SLOW,
      ZONE_END
   } zone_type;

   zone_type                                zone;
   logic                                    right_chg;
   logic                                    left_chg;
   logic [rssp_pkg::PosW-1:0]               offset_new;
   logic signed [rssp_pkg::PosW-1:0]        pos;
   logic [rssp_pkg::SpeedW:0]               sum;
   logic [rssp_pkg::SpeedW-1:0]             step_ext;
   logic [rssp_pkg::SpeedW-1:0]             up_speed;
   logic [rssp_pkg::SpeedW-1:0]             dec_speed;
   logic [rssp_pkg::SpeedW-1:0]             slow_speed;
   logic [rssp_pkg::SpeedW-1:0]             speed_new;
   logic [rssp_pkg::PosW:0]                 rpm_ext;
   logic [rssp_pkg::PosW:0]                 rpm_mag;
   logic                                    reverse;
   logic                                    dir_new;
   logic [rssp_pkg::CmdW-1:0]               spd_ext;

   always_comb begin
      right_chg = item.right_beam != state.last_right_beam;
      left_chg  = item.left_beam != state.last_left_beam;
      if (left_chg) begin
         offset_new = (state.travel_right ? rssp_pkg::LmLeftR : rssp_pkg::LmLeftL)
                      - item.encoder_position;
      end else if (right_chg) begin
         offset_new = (state.travel_right ? rssp_pkg::LmRightR : rssp_pkg::LmRightL)
                      - item.encoder_position;
      end else begin
         offset_new = state.offset;
      end
      pos = offset_new + item.encoder_position;
   end

   always_comb begin
      if (!state.travel_right) begin
         if (pos > rssp_pkg::ZlA)      zone = ZONE_UP;
         else if (pos > rssp_pkg::ZlB) zone = ZONE_SLOW;
         else if (pos > rssp_pkg::ZlC) zone = ZONE_UP;
         else                          zone = ZONE_END;
      end else begin
         if (pos < rssp_pkg::ZrA)      zone = ZONE_UP;
         else if (pos < rssp_pkg::ZrB) zone = ZONE_SLOW;
         else if (pos < rssp_pkg::ZrC) zone = ZONE_UP;
         else                          zone = ZONE_END;
      end
   end

   always_comb begin
      step_ext = {{(rssp_pkg::SpeedW-rssp_pkg::StepW){1'b0}}, cfg.speed_step};
      sum      = {1'b0, state.speed} + {1'b0, step_ext};
      up_speed = (sum > {1'b0, cfg.max_speed}) ? cfg.max_speed
                                               : sum[rssp_pkg::SpeedW-1:0];
      dec_speed  = (state.speed > step_ext) ? state.speed - step_ext : '0;
      slow_speed = (state.speed > cfg.slow_speed) ? dec_speed : cfg.slow_speed;
      rpm_ext    = {item.motor_speed[rssp_pkg::PosW-1], item.motor_speed};
      rpm_mag    = rpm_ext[rssp_pkg::PosW] ? (~rpm_ext + 1'b1) : rpm_ext;
      reverse    = 1'b0;
      case (zone)
         ZONE_UP:   speed_new = up_speed;
         ZONE_SLOW: speed_new = slow_speed;
         ZONE_END: begin
            speed_new = dec_speed;
            reverse   = rpm_mag < {{(rssp_pkg::PosW+1-rssp_pkg::RpmW){1'b0}}, cfg.stop_rpm};
         end
         default:   speed_new = state.speed;
      endcase
      dir_new = state.travel_right ^ reverse;
      spd_ext = {1'b0, speed_new};
   end

   always_comb begin
      state_next.travel_right    = dir_new;
      state_next.speed           = speed_new;
      state_next.offset          = offset_new;
      state_next.last_right_beam = item.right_beam;
      state_next.last_left_beam  = item.left_beam;
      result.speed_command       = dir_new ? spd_ext : (~spd_ext + 1'b1);
      result.moving_right        = dir_new;
      result.track_position      = pos;
   end

endmodule

/* rtl/rail_shuttle_speed_profile.sv */
// Pipeline: a req word is held in the input reg, then in the result reg, which drives the rsp word.
// Throughput: 1 word per cycle while rsp_tready is high; req_tready stays high while the result reg drains.
// The carriage state update is one pass of compare/add logic, done as a word moves
// from the input reg into the result reg.
// Reset (synchronous): CSR registers return to defaults, moving left, speed 0, offset 0.
module rail_shuttle_speed_profile (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rssp_pkg::CsrAddrW-1:0]     csr_addr,
   input  logic [rssp_pkg::CsrDataW-1:0]     csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // right_beam, left_beam, encoder_position[15:0], motor_speed[15:0], zero pad
   input  logic [rssp_pkg::ReqDataW-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // speed_command[14:0], moving_right, track_position[15:0]
   output logic [rssp_pkg::RspDataW-1:0]     rsp_tdata
);

   rssp_pkg::cfg_type    cfg_ff;
   rssp_pkg::state_type  state_ff;
   rssp_pkg::state_type  state_in;
   rssp_pkg::item_type   item_ff;
   rssp_pkg::item_type   item_in;
   rssp_pkg::result_type result_ff;
   rssp_pkg::result_type result_in;
   logic                 in_valid_ff;
   logic                 out_valid_ff;
   logic                 advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {result_ff.track_position, result_ff.moving_right,
                        result_ff.speed_command};

   assign item_in.right_beam       = req_tdata[0];
   assign item_in.left_beam        = req_tdata[1];
   assign item_in.encoder_position = req_tdata[17:2];
   assign item_in.motor_speed      = req_tdata[33:18];

   rssp_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed  <= rssp_pkg::MaxSpeedRst;
         cfg_ff.slow_speed <= rssp_pkg::SlowSpeedRst;
         cfg_ff.speed_step <= rssp_pkg::SpeedStepRst;
         cfg_ff.stop_rpm   <= rssp_pkg::StopRpmRst;
      end else if (csr_we) begin
         case (rssp_pkg::csr_addr_type'(csr_addr))
            rssp_pkg::CSR_MAX_SPEED:  cfg_ff.max_speed  <= csr_wdata;
            rssp_pkg::CSR_SLOW_SPEED: cfg_ff.slow_speed <= csr_wdata;
            rssp_pkg::CSR_SPEED_STEP: cfg_ff.speed_step <= csr_wdata[rssp_pkg::StepW-1:0];
            rssp_pkg::CSR_STOP_RPM:   cfg_ff.stop_rpm   <= csr_wdata[rssp_pkg::RpmW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.travel_right    <= 1'b0;
         state_ff.speed           <= '0;
         state_ff.offset          <= '0;
         state_ff.last_right_beam <= 1'b0;
         state_ff.last_left_beam  <= 1'b1;
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

`ifndef SYNTH
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stage empty but not ready");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted word lost from input stage");

   a_dir_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff.travel_right))
      else $error("direction changed without a word");

   a_dir_match: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (result_ff.moving_right == state_ff.travel_right))
      else $error("pending result disagrees with direction state");
`endif

endmodule

/* tb/rail_shuttle_speed_profile_checker.sv */
`timescale 1ns / 100ps

module rail_shuttle_speed_profile_checker
   import rssp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_tvalid,
   input  logic                req_tready,
   // right_beam, left_beam, encoder_position[15:0], motor_speed[15:0], zero pad
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   // speed_command[14:0], moving_right, track_position[15:0]
   input  logic [RspDataW-1:0] rsp_tdata,
   output int                  fail_count,
   output int                  outstanding
);

   typedef enum logic [1:0] {
      ZONE_RAMP_UP,
      ZONE_SLOW_DOWN,
      ZONE_END
   } zone_type;

   logic [SpeedW-1:0] max_spd;
   logic [SpeedW-1:0] slow_spd;
   logic [StepW-1:0]  spd_step;
   logic [RpmW-1:0]   stop_mag;

   logic              dir_right;
   logic [SpeedW-1:0] cur_spd;
   logic [PosW-1:0]   pos_ofs;
   logic              prev_rb;
   logic              prev_lb;

   result_type        cmd_q[$];
   int                fails = 0;
   int                pending = 0;

   assign fail_count  = fails;
   assign outstanding = pending;

   function automatic result_type next_speed_cmd(input logic rb, input logic lb,
                                                 input logic [PosW-1:0] enc,
                                                 input logic signed [PosW-1:0] rpm);
      logic signed [PosW-1:0] pos;
      zone_type               zone;
      int                     spd;
      int                     mag;
      result_type             res;
      if (rb != prev_rb) pos_ofs = (dir_right ? LmRightR : LmRightL) - enc;
      if (lb != prev_lb) pos_ofs = (dir_right ? LmLeftR : LmLeftL) - enc;
      prev_rb = rb;
      prev_lb = lb;
      pos = pos_ofs + enc;
      if (!dir_right) begin
         zone = (pos > ZlA) ? ZONE_RAMP_UP : (pos > ZlB) ? ZONE_SLOW_DOWN :
                (pos > ZlC) ? ZONE_RAMP_UP : ZONE_END;
      end else begin
         zone = (pos < ZrA) ? ZONE_RAMP_UP : (pos < ZrB) ? ZONE_SLOW_DOWN :
                (pos < ZrC) ? ZONE_RAMP_UP : ZONE_END;
      end
      spd = int'(cur_spd);
      case (zone)
         ZONE_RAMP_UP: begin
            spd = spd + int'(spd_step);
            if (spd > int'(max_spd)) spd = int'(max_spd);
         end
         ZONE_SLOW_DOWN: begin
            if (spd > int'(slow_spd)) spd = (spd > int'(spd_step)) ? spd - int'(spd_step) : 0;
            else spd = int'(slow_spd);
         end
         default: begin
            spd = (spd > int'(spd_step)) ? spd - int'(spd_step) : 0;
            mag = rpm;
            if (mag < 0) mag = -mag;
            if (mag < int'(stop_mag)) dir_right = !dir_right;
         end
      endcase
      cur_spd = spd[SpeedW-1:0];
      res.speed_command  = dir_right ? CmdW'(spd) : CmdW'(-spd);
      res.moving_right   = dir_right;
      res.track_position = pos;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         max_spd   = MaxSpeedRst;
         slow_spd  = SlowSpeedRst;
         spd_step  = SpeedStepRst;
         stop_mag  = StopRpmRst;
         dir_right = 1'b0;
         cur_spd   = '0;
         pos_ofs   = '0;
         prev_rb   = 1'b0;
         prev_lb   = 1'b1;
         cmd_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr_type'(csr_addr))
               CSR_MAX_SPEED:  max_spd  = csr_wdata[SpeedW-1:0];
               CSR_SLOW_SPEED: slow_spd = csr_wdata[SpeedW-1:0];
               CSR_SPEED_STEP: spd_step = csr_wdata[StepW-1:0];
               CSR_STOP_RPM:   stop_mag = csr_wdata[RpmW-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.speed_command  = rsp_tdata[14:0];
            got.moving_right   = rsp_tdata[15];
            got.track_position = rsp_tdata[31:16];
            if (cmd_q.size() == 0) begin
               $error("rsp word with no expected result: %h", rsp_tdata);
               fails++;
            end else begin
               want = cmd_q.pop_front();
               if (got.speed_command !== want.speed_command) begin
                  $error("speed_command: expected %0d, got %0d",
                         want.speed_command, got.speed_command);
                  fails++;
               end
               if (got.moving_right !== want.moving_right) begin
                  $error("moving_right: expected %0d, got %0d",
                         want.moving_right, got.moving_right);
                  fails++;
               end
               if (got.track_position !== want.track_position) begin
                  $error("track_position: expected %0d, got %0d",
                         want.track_position, got.track_position);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cmd_q.push_back(next_speed_cmd(req_tdata[0], req_tdata[1],
                                           req_tdata[17:2], req_tdata[33:18]));
         end
      end
      pending <= cmd_q.size();
   end

endmodule

/* tb/rail_shuttle_speed_profile_test.sv */
`timescale 1ns / 100ps

module rail_shuttle_speed_profile_test;
   import rssp_pkg::*;

   localparam int DrainCycles = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   int                  fail_count;
   int                  outstanding;

   bit                  quiet = 1'b0;
   int                  stall_left = 0;
   int                  sweep_p = 0;
   int                  sweep_dir = -1;
   logic [PosW-1:0]     enc_base = '0;

   rail_shuttle_speed_profile u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rail_shuttle_speed_profile_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (quiet || $urandom_range(0, 99) >= 30) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= idle_len() - 1;
      end
   end

   task automatic send_word(input logic rb, input logic lb, input logic [PosW-1:0] enc,
                            input logic [PosW-1:0] rpm);
      int gap;
      gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, rpm, enc, lb, rb};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (outstanding != 0 && guard < 5000);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_config(input logic [SpeedW-1:0] mx, input logic [SpeedW-1:0] sl,
                               input logic [StepW-1:0] st, input logic [RpmW-1:0] rp);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MAX_SPEED;
      csr_wdata <= mx;
      @(posedge clock);
      csr_addr  <= CSR_SLOW_SPEED;
      csr_wdata <= sl;
      @(posedge clock);
      csr_addr  <= CSR_SPEED_STEP;
      csr_wdata <= CsrDataW'(st);
      @(posedge clock);
      csr_addr  <= CSR_STOP_RPM;
      csr_wdata <= CsrDataW'(rp);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // carriage sweeping along the rail, with some chatter and raw noise mixed in
   task automatic send_shuttle_word();
      int              r;
      int              rpm_i;
      logic            rb;
      logic            lb;
      logic [PosW-1:0] enc;
      logic [PosW-1:0] rpm;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         rb  = $urandom_range(0, 1);
         lb  = $urandom_range(0, 1);
         enc = PosW'($urandom);
         rpm = ($urandom_range(0, 7) == 0) ? 16'h8000 : PosW'($urandom);
      end else begin
         sweep_p += sweep_dir * int'($urandom_range(0, 12));
         if (sweep_p > 10) sweep_dir = -1;
         else if (sweep_p < -340) sweep_dir = 1;
         rb = sweep_p > -85;
         lb = sweep_p > -255;
         if (r < 20) rb = ~rb;
         if ($urandom_range(0, 63) == 0) enc_base += PosW'($urandom_range(0, 31)) - 16'd16;
         enc = PosW'(sweep_p) + enc_base;
         if (sweep_p < -295 || sweep_p > -40) begin
            rpm_i = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 10))
                                                : int'($urandom_range(0, 300));
            if ($urandom_range(0, 1) == 0) rpm_i = -rpm_i;
         end else begin
            rpm_i = sweep_dir * int'($urandom_range(200, 9000));
         end
         rpm = PosW'(rpm_i);
      end
      send_word(rb, lb, enc, rpm);
   endtask

   initial begin
      int              left_marks[7];
      int              right_marks[6];
      logic [PosW-1:0] ofs;
      int              phase;
      int              n;
      left_marks  = '{-150, -151, -200, -240, -241, -302, -303};
      right_marks = '{-246, -245, -161, -160, -32, -31};
      enc_base    = PosW'($urandom);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: landmarks, zone edges, end-zone reversal, both beams at once
      send_word(1'b0, 1'b1, 16'h0000, 16'sd100);
      send_word(1'b1, 1'b1, 16'h0000, 16'sd100);
      send_word(1'b1, 1'b0, 16'h8000, 16'sd200);
      ofs = PosW'(LmLeftL) - 16'h8000;
      foreach (left_marks[i]) send_word(1'b1, 1'b0, PosW'(left_marks[i]) - ofs, 16'sd300);
      send_word(1'b1, 1'b0, PosW'(-310) - ofs, 16'h8000);
      send_word(1'b1, 1'b0, PosW'(-310) - ofs, 16'h7FFF);
      send_word(1'b1, 1'b0, PosW'(-310) - ofs, 16'sd5);
      send_word(1'b1, 1'b0, PosW'(-310) - ofs, -16'sd4);
      foreach (right_marks[i]) send_word(1'b1, 1'b0, PosW'(right_marks[i]) - ofs, 16'sd300);
      send_word(1'b0, 1'b1, 16'h7FFF, 16'sd300);
      ofs = PosW'(LmLeftR) - 16'h7FFF;
      send_word(1'b0, 1'b1, 16'h0000 - ofs, 16'sd0);
      send_word(1'b0, 1'b1, PosW'(-20) - ofs, 16'sd100);

      for (phase = 0; phase < 7; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: write_config(14'd16383, 14'd16383, 12'd4095, 8'd255);
               2: write_config(14'd0, 14'd0, 12'd1, 8'd0);
               3: write_config(14'd16383, 14'd0, 12'd1, 8'd255);
               4: write_config(14'd3000, 14'd9000, 12'd700, 8'd20);
               default: write_config(SpeedW'($urandom_range(0, 16383)),
                                     SpeedW'($urandom_range(0, 16383)),
                                     StepW'($urandom_range(1, 4095)),
                                     RpmW'($urandom_range(0, 255)));
            endcase
         end
         quiet = (phase == 3);
         for (n = 0; n < 280; n++) begin
            if (phase == 4 && n == 140) wait_idle();
            if (phase == 5) quiet = (n >= 100 && n < 200);
            send_shuttle_word();
         end
      end
      quiet = 1'b0;

      wait_idle();
      if (outstanding != 0) $error("%0d expected rsp words never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
